@@ src/sfr_pkg.sv @@
// Shared types and constants for the sequenced fragment reassembler.
// No dependencies.
package sfr_pkg;

  // Header delimiter characters.
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Parse phase codes.
  localparam logic [1:0] PH_INDEX   = 2'd0;
  localparam logic [1:0] PH_TOTAL   = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [1:0] PH_DISCARD = 2'd3;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       message_end;
    logic       message_abort;
  } result_t;

  // Load request from the parser into the output stage.
  typedef struct packed {
    logic    load;
    result_t result;
  } result_req_t;

endpackage

@@ src/sfr_in_if.sv @@
// Input channel of the reassembler: one datagram byte per request.
// Depends on nothing.
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       datagram_end;

  modport source (output valid, output data_byte, output datagram_end, input ready);
  modport sink   (input valid, input data_byte, input datagram_end, output ready);
endinterface

@@ src/sfr_out_if.sv @@
// Output channel of the reassembler: one result item per request.
// Depends on nothing.
interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       byte_valid;
  logic       message_end;
  logic       message_abort;

  modport source (output valid, output payload_byte, output byte_valid,
                  output message_end, output message_abort, input ready);
  modport sink   (input valid, input payload_byte, input byte_valid,
                  input message_end, input message_abort, output ready);
endinterface

@@ src/sfr_digit_acc.sv @@
// Decimal digit accumulator for one header number.
// Depends on sfr_pkg.
module sfr_digit_acc #(
  parameter int COUNT_BITS = 16
) (
  input  logic [7:0]            data_byte,
  input  logic [COUNT_BITS-1:0] value,
  input  logic                  bad,
  output logic [COUNT_BITS-1:0] value_next,
  output logic                  bad_next
);
  import sfr_pkg::*;

  localparam int WIDE_W = COUNT_BITS + 4;

  logic              is_digit;
  logic [3:0]        digit;
  logic [WIDE_W-1:0] wide;

  assign is_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
  assign digit    = data_byte[3:0];
  // value * 10 + digit as two shifts and two adds.
  assign wide = {1'b0, value, 3'b000} + {3'b000, value, 1'b0} + WIDE_W'(digit);

  always_comb begin
    value_next = value;
    bad_next   = bad;
    if (!bad) begin
      if (!is_digit) begin
        bad_next = 1'b1;
      end else begin
        value_next = wide[COUNT_BITS-1:0];
        bad_next   = (wide[WIDE_W-1:COUNT_BITS] != '0);
      end
    end
  end
endmodule

@@ src/sfr_out_stage.sv @@
// Output register of the reassembler; decouples the result side from the input.
// Depends on sfr_pkg and sfr_out_if.
module sfr_out_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  sfr_pkg::result_req_t  req,
  output logic                  room,
  sfr_out_if.source             outbound
);
  import sfr_pkg::*;

  logic    full;
  result_t held;

  assign room = !full || outbound.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (room) begin
      full <= take && req.load;
    end
  end

  always_ff @(posedge clk) begin
    if (room && take && req.load) begin
      held <= req.result;
    end
  end

  assign outbound.valid         = full;
  assign outbound.payload_byte  = held.payload_byte;
  assign outbound.byte_valid    = held.byte_valid;
  assign outbound.message_end   = held.message_end;
  assign outbound.message_abort = held.message_abort;
endmodule

@@ src/sequenced_fragment_reassembler.sv @@
// Top level of the sequenced fragment reassembler: header parser, sequence check.
// Depends on sfr_pkg, sfr_in_if, sfr_out_if, sfr_digit_acc and sfr_out_stage.
//
// Datagram bytes arrive one per request, the last byte of each datagram flagged
// by datagram_end. Every datagram opens with an ASCII header "index/total:";
// a bad digit or a number above 2^COUNT_BITS-1 reads as zero. The fragment count
// (total minus index) must be one less than that of the previous fragment; with
// no payload gathered yet the expected count simply follows the header. Payload
// bytes of an accepted fragment stream out one per result, and the last byte of
// the fragment whose count is one carries message_end (a final fragment with an
// empty payload gives a lone message_end). A count that does not fit gives a
// single message_abort result and the rest of that datagram is dropped; a
// datagram that ends inside its header is dropped silently. The block takes one
// byte every clock while ready is high: parsing and checking is combinational logic
// on the state registers, and the result lands in an output register in the cycle
// after its byte is accepted. Input ready drops only while that register holds
// a result that the sink has not taken.
module sequenced_fragment_reassembler #(
  parameter int COUNT_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  sfr_in_if.sink   inbound,
  sfr_out_if.source outbound
);
  import sfr_pkg::*;

  localparam int EXP_W = COUNT_BITS + 2;

  // Parser and sequence state.
  logic [1:0]              parse_phase, parse_phase_next;
  logic [COUNT_BITS-1:0]   index_value, index_value_next;
  logic                    index_bad, index_bad_next;
  logic [COUNT_BITS-1:0]   total_value, total_value_next;
  logic                    total_bad, total_bad_next;
  logic signed [EXP_W-1:0] expected_remaining, expected_remaining_next;
  logic                    has_payload, has_payload_next;
  logic                    final_fragment, final_fragment_next;

  logic [COUNT_BITS-1:0] idx_acc_value, tot_acc_value;
  logic                  idx_acc_bad, tot_acc_bad;

  logic signed [EXP_W-1:0] first_num, second_num, count, expected_cmp;
  logic                    count_match;

  logic        take;
  logic        room;
  logic [7:0]  b;
  logic        last;
  result_req_t req;

  assign b    = inbound.data_byte;
  assign last = inbound.datagram_end;

  // A byte is taken whenever the output register can hold its result.
  assign inbound.ready = room;
  assign take          = inbound.valid && room;

  sfr_digit_acc #(.COUNT_BITS(COUNT_BITS)) u_idx_acc (
    .data_byte  (b),
    .value      (index_value),
    .bad        (index_bad),
    .value_next (idx_acc_value),
    .bad_next   (idx_acc_bad)
  );

  sfr_digit_acc #(.COUNT_BITS(COUNT_BITS)) u_tot_acc (
    .data_byte  (b),
    .value      (total_value),
    .bad        (total_bad),
    .value_next (tot_acc_value),
    .bad_next   (tot_acc_bad)
  );

  // Header numbers as signed counts; a bad number counts as zero.
  assign first_num  = index_bad ? '0 : EXP_W'(index_value);
  assign second_num = total_bad ? '0 : EXP_W'(total_value);
  assign count      = second_num - first_num;
  // With nothing gathered the expected count resynchronizes to this header.
  assign expected_cmp = has_payload ? expected_remaining : count + EXP_W'(1);
  assign count_match  = (count == expected_cmp - EXP_W'(1));

  always_comb begin
    parse_phase_next        = parse_phase;
    index_value_next        = index_value;
    index_bad_next          = index_bad;
    total_value_next        = total_value;
    total_bad_next          = total_bad;
    expected_remaining_next = expected_remaining;
    has_payload_next        = has_payload;
    final_fragment_next     = final_fragment;
    req                     = '0;

    case (parse_phase)
      PH_INDEX: begin
        if (b == CHAR_SLASH) begin
          parse_phase_next = PH_TOTAL;
        end else begin
          index_value_next = idx_acc_value;
          index_bad_next   = idx_acc_bad;
        end
        if (last) begin
          // Header cut short: drop the datagram without a result.
          parse_phase_next = PH_INDEX;
          index_value_next = '0;
          index_bad_next   = 1'b0;
          total_value_next = '0;
          total_bad_next   = 1'b0;
        end
      end
      PH_TOTAL: begin
        if (b != CHAR_COLON) begin
          total_value_next = tot_acc_value;
          total_bad_next   = tot_acc_bad;
          if (last) begin
            parse_phase_next = PH_INDEX;
            index_value_next = '0;
            index_bad_next   = 1'b0;
            total_value_next = '0;
            total_bad_next   = 1'b0;
          end
        end else begin
          index_value_next = '0;
          index_bad_next   = 1'b0;
          total_value_next = '0;
          total_bad_next   = 1'b0;
          if (count_match) begin
            expected_remaining_next = count;
            final_fragment_next     = (count == EXP_W'(1));
            parse_phase_next        = PH_PAYLOAD;
            if (last) begin
              parse_phase_next = PH_INDEX;
              if (count == EXP_W'(1)) begin
                // Final fragment with no payload still closes the message.
                req.load                = 1'b1;
                req.result.message_end  = 1'b1;
                has_payload_next        = 1'b0;
                expected_remaining_next = EXP_W'(1);
                final_fragment_next     = 1'b0;
              end
            end
          end else begin
            req.load                 = 1'b1;
            req.result.message_abort = 1'b1;
            has_payload_next         = 1'b0;
            expected_remaining_next  = EXP_W'(1);
            final_fragment_next      = 1'b0;
            parse_phase_next         = last ? PH_INDEX : PH_DISCARD;
          end
        end
      end
      PH_PAYLOAD: begin
        req.load                = 1'b1;
        req.result.payload_byte = b;
        req.result.byte_valid   = 1'b1;
        if (last && final_fragment) begin
          req.result.message_end  = 1'b1;
          has_payload_next        = 1'b0;
          expected_remaining_next = EXP_W'(1);
          final_fragment_next     = 1'b0;
        end else begin
          has_payload_next = 1'b1;
        end
        if (last) begin
          parse_phase_next = PH_INDEX;
        end
      end
      default: begin
        // Discarding the rest of a rejected datagram.
        if (last) begin
          parse_phase_next = PH_INDEX;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase        <= PH_INDEX;
      index_value        <= '0;
      index_bad          <= 1'b0;
      total_value        <= '0;
      total_bad          <= 1'b0;
      expected_remaining <= EXP_W'(1);
      has_payload        <= 1'b0;
      final_fragment     <= 1'b0;
    end else if (take) begin
      parse_phase        <= parse_phase_next;
      index_value        <= index_value_next;
      index_bad          <= index_bad_next;
      total_value        <= total_value_next;
      total_bad          <= total_bad_next;
      expected_remaining <= expected_remaining_next;
      has_payload        <= has_payload_next;
      final_fragment     <= final_fragment_next;
    end
  end

  sfr_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .req      (req),
    .room     (room),
    .outbound (outbound)
  );
endmodule

@@ src/sfr_checker.sv @@
// Port-level checks for the sequenced fragment reassembler, bound to the top.
// Depends on sequenced_fragment_reassembler.
module sfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] payload_byte,
  input logic       byte_valid,
  input logic       message_end,
  input logic       message_abort
);

  // An abort never carries a byte and never closes a message.
  a_abort_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && message_abort |-> !byte_valid && !message_end)
    else $error("abort result carries data or message end");

  // Results without a real byte show a zero payload.
  a_empty_payload_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> payload_byte == 8'h00)
    else $error("payload nonzero without byte_valid");

  // Every result is something: a byte, an end or an abort.
  a_result_meaningful: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> byte_valid || message_end || message_abort)
    else $error("empty result item");

  // Input is held off only while a result waits at the output.
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with free output register");

  // A stalled result keeps its contents.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(payload_byte) &&
      $stable(byte_valid) && $stable(message_end) && $stable(message_abort))
    else $error("stalled result changed");

endmodule

bind sequenced_fragment_reassembler sfr_checker u_sfr_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (inbound.ready),
  .out_valid     (outbound.valid),
  .out_ready     (outbound.ready),
  .payload_byte  (outbound.payload_byte),
  .byte_valid    (outbound.byte_valid),
  .message_end   (outbound.message_end),
  .message_abort (outbound.message_abort)
);
